/* hdl/ray_square_closest_hit_core_macros.svh */
// ----------------------------------------------------------------------------
// ray_square_closest_hit_core_macros
// assertion helpers shared by the closest-hit core
// ----------------------------------------------------------------------------
`ifndef RAY_SQUARE_CLOSEST_HIT_CORE_MACROS_SVH
`define RAY_SQUARE_CLOSEST_HIT_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RSCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsch assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define RSCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsch assertion failed");

`endif

/* hdl/rsch_pkg.sv */
// ----------------------------------------------------------------------------
// rsch_pkg
// types, codes and helpers for the ray/square closest-hit core
// ----------------------------------------------------------------------------
`default_nettype none
package rsch_pkg;

  localparam int unsigned DivSteps = 48;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  // multiplier operand pair codes
  localparam logic [3:0] MUL_DA0 = 4'd0;
  localparam logic [3:0] MUL_DA1 = 4'd1;
  localparam logic [3:0] MUL_DA2 = 4'd2;
  localparam logic [3:0] MUL_DB0 = 4'd3;
  localparam logic [3:0] MUL_DB1 = 4'd4;
  localparam logic [3:0] MUL_DB2 = 4'd5;
  localparam logic [3:0] MUL_PT0 = 4'd6;
  localparam logic [3:0] MUL_PT1 = 4'd7;
  localparam logic [3:0] MUL_PT2 = 4'd8;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        side_width;
    logic [15:0]        square_index;
    logic               last_square;
  } rsch_in_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        best_square;
    logic [30:0]        hit_distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] surf_normal_x;
    logic signed [31:0] surf_normal_y;
    logic signed [31:0] surf_normal_z;
  } rsch_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DOT, ST_CHK, ST_DIV, ST_PT, ST_UPD, ST_FIN
  } rsch_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       cap;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       acc_en;
    logic [3:0] acc_sel;
    logic       div_init;
    logic       div_step;
    logic       pt_en;
    logic [1:0] pt_sel;
    logic       upd;
    logic       out_load;
  } rsch_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic reject;
    logic last;
    logic out_free;
  } rsch_stat_t;

  // saturate to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round a Q32.32 product to Q32.16
  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd32768) >>> 16;
    return s[47:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/rsch_ctrl.sv */
// ----------------------------------------------------------------------------
// rsch_ctrl
// sequencer: dot products, divide, hit point test, update and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module rsch_ctrl import rsch_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire rsch_stat_t stat_i,
  output rsch_cmd_t       cmd_o
);

  rsch_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 6'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_DOT;
      end
      ST_DOT: begin
        if (cnt_q == 6'd6) begin
          state_d = ST_CHK;
          cnt_d   = '0;
        end
      end
      ST_CHK: begin
        cnt_d   = '0;
        state_d = stat_i.reject ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == 6'(DivSteps - 1)) begin
          state_d = ST_PT;
          cnt_d   = '0;
        end
      end
      ST_PT: begin
        if (cnt_q == 6'd3) begin
          state_d = ST_UPD;
          cnt_d   = '0;
        end
      end
      ST_UPD: begin
        cnt_d   = '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        cnt_d = '0;
        if (!stat_i.last || stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      ST_DOT: begin
        cmd_o.mul_en  = (cnt_q < 6'd6);
        cmd_o.mul_sel = cnt_q[3:0];
        cmd_o.acc_en  = (cnt_q != 6'd0);
        cmd_o.acc_sel = cnt_q[3:0] - 4'd1;
      end
      ST_CHK: cmd_o.div_init = !stat_i.reject;
      ST_DIV: cmd_o.div_step = 1'b1;
      ST_PT: begin
        cmd_o.mul_en  = (cnt_q < 6'd3);
        cmd_o.mul_sel = MUL_PT0 + cnt_q[3:0];
        cmd_o.pt_en   = (cnt_q != 6'd0);
        cmd_o.pt_sel  = cnt_q[1:0] - 2'd1;
      end
      ST_UPD: cmd_o.upd = 1'b1;
      ST_FIN: cmd_o.out_load = stat_i.last && stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/rsch_dp.sv */
// ----------------------------------------------------------------------------
// rsch_dp
// datapath: ray registers, shared multiplier, divider, nearest-hit state
// ----------------------------------------------------------------------------
`default_nettype none
module rsch_dp import rsch_pkg::*; #(
  parameter int unsigned EPS_LSB    = 1,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire rsch_in_t    in_data_i,
  input  wire rsch_cmd_t   cmd_i,
  output rsch_stat_t       stat_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsch_out_t        out_data_o
);

  localparam int unsigned KeepBits = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam logic [15:0] IdxMask  = 16'((33'd1 << KeepBits) - 33'd1);
  localparam logic [31:0] Eps      = 32'(EPS_LSB);

  logic signed [31:0] org_q [3];
  logic signed [31:0] dir_q [3];
  logic [30:0]        maxd_q;

  logic signed [31:0] dif_q [3];
  logic signed [31:0] cen_q [3];
  logic signed [31:0] nrm_q [3];
  logic [29:0]        half_q;
  logic [15:0]        idx_q;
  logic               last_q;

  logic signed [63:0] mul_q;
  logic signed [49:0] acc_q;
  logic signed [31:0] a_q, b_q;
  logic [32:0]        rem_q;
  logic [47:0]        quo_q;
  logic [32:0]        dvs_q;
  logic signed [31:0] pt_q [3];
  logic               fail_q;

  logic               any_q;
  logic [30:0]        nd_q;
  logic [15:0]        ni_q;
  logic signed [31:0] np_q [3];
  logic signed [31:0] nn_q [3];

  // ray configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
      dir_q[0] <= '0; dir_q[1] <= '0; dir_q[2] <= 32'sd65536;
      maxd_q   <= 31'h7FFFFFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X: org_q[0] <= cfg_data_i;
        REG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        REG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        REG_DIR_X:    dir_q[0] <= cfg_data_i;
        REG_DIR_Y:    dir_q[1] <= cfg_data_i;
        REG_DIR_Z:    dir_q[2] <= cfg_data_i;
        REG_MAX_DIST: maxd_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // item capture, origin minus centre saturated
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cen_q[0] <= in_data_i.center_x;
      cen_q[1] <= in_data_i.center_y;
      cen_q[2] <= in_data_i.center_z;
      nrm_q[0] <= in_data_i.normal_x;
      nrm_q[1] <= in_data_i.normal_y;
      nrm_q[2] <= in_data_i.normal_z;
      dif_q[0] <= sat32(64'(org_q[0]) - 64'(in_data_i.center_x));
      dif_q[1] <= sat32(64'(org_q[1]) - 64'(in_data_i.center_y));
      dif_q[2] <= sat32(64'(org_q[2]) - 64'(in_data_i.center_z));
      half_q   <= in_data_i.side_width[30:1];
      idx_q    <= in_data_i.square_index & IdxMask;
      last_q   <= in_data_i.last_square;
    end
  end

  // clamped quotient is the ray parameter
  logic [30:0] t_w;
  assign t_w = (quo_q[47:31] != '0) ? 31'h7FFFFFFF : quo_q[30:0];

  // shared multiplier operand select
  logic signed [31:0] op_a, op_b;
  always_comb begin
    op_a = dif_q[0];
    op_b = nrm_q[0];
    case (cmd_i.mul_sel)
      MUL_DA0: begin op_a = dif_q[0]; op_b = nrm_q[0]; end
      MUL_DA1: begin op_a = dif_q[1]; op_b = nrm_q[1]; end
      MUL_DA2: begin op_a = dif_q[2]; op_b = nrm_q[2]; end
      MUL_DB0: begin op_a = dir_q[0]; op_b = nrm_q[0]; end
      MUL_DB1: begin op_a = dir_q[1]; op_b = nrm_q[1]; end
      MUL_DB2: begin op_a = dir_q[2]; op_b = nrm_q[2]; end
      MUL_PT0: begin op_a = dir_q[0]; op_b = {1'b0, t_w}; end
      MUL_PT1: begin op_a = dir_q[1]; op_b = {1'b0, t_w}; end
      MUL_PT2: begin op_a = dir_q[2]; op_b = {1'b0, t_w}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) mul_q <= op_a * op_b;
  end

  // rounded product and dot product accumulation
  logic signed [47:0] rnd_w;
  logic signed [49:0] acc_base, acc_sum;
  assign rnd_w    = rnd16(mul_q);
  assign acc_base = (cmd_i.acc_sel == MUL_DA0 || cmd_i.acc_sel == MUL_DB0) ? '0 : acc_q;
  assign acc_sum  = acc_base + 50'(rnd_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      acc_q <= acc_sum;
      if (cmd_i.acc_sel == MUL_DA2) a_q <= sat32(64'(acc_sum));
      if (cmd_i.acc_sel == MUL_DB2) b_q <= sat32(64'(acc_sum));
    end
  end

  // parallel, same sign and near-zero rejects
  logic [32:0] a_abs, b_abs;
  assign a_abs = a_q[31] ? 33'(-34'(a_q)) : 33'(a_q);
  assign b_abs = b_q[31] ? 33'(-34'(b_q)) : 33'(b_q);
  assign stat_o.reject = (b_q == '0) || (b_abs < 33'(Eps)) ||
                         (a_q[31] && b_q[31]) ||
                         (!a_q[31] && a_q != '0 && !b_q[31] && b_q != '0);

  // restoring divider, one quotient bit per cycle
  logic [32:0] trial;
  assign trial = {rem_q[31:0], quo_q[47]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= {a_abs[31:0], 16'h0000};
      dvs_q <= b_abs;
    end else if (cmd_i.div_step) begin
      if (trial >= dvs_q) begin
        rem_q <= trial - dvs_q;
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  // hit point per axis and offset test
  logic signed [31:0] pt_w;
  logic signed [32:0] off_w;
  logic [32:0]        off_abs;
  always_comb begin
    pt_w    = sat32(64'(org_q[cmd_i.pt_sel]) + 64'(rnd_w));
    off_w   = 33'(pt_w) - 33'(cen_q[cmd_i.pt_sel]);
    off_abs = off_w[32] ? 33'(-off_w) : 33'(off_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= 1'b0;
    end else if (cmd_i.cap) begin
      fail_q <= 1'b0;
    end else if (cmd_i.pt_en && off_abs > 33'(half_q)) begin
      fail_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_en) pt_q[cmd_i.pt_sel] <= pt_w;
  end

  // nearest hit update and re-arm
  logic [30:0] bound;
  logic        take;
  assign bound = any_q ? nd_q : maxd_q;
  assign take  = cmd_i.upd && !fail_q && (32'(t_w) > Eps) && (t_w < bound);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      any_q <= 1'b0;
    end else if (take) begin
      any_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      nd_q  <= t_w;
      ni_q  <= idx_q;
      np_q  <= pt_q;
      nn_q  <= nrm_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= '0;
      if (any_q) begin
        out_data_o.found         <= 1'b1;
        out_data_o.best_square   <= ni_q;
        out_data_o.hit_distance  <= nd_q;
        out_data_o.hit_x         <= np_q[0];
        out_data_o.hit_y         <= np_q[1];
        out_data_o.hit_z         <= np_q[2];
        out_data_o.surf_normal_x <= nn_q[0];
        out_data_o.surf_normal_y <= nn_q[1];
        out_data_o.surf_normal_z <= nn_q[2];
      end
    end
  end

  assign stat_o.last     = last_q;
  assign stat_o.out_free = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

/* hdl/ray_square_closest_hit_core.sv */
// ----------------------------------------------------------------------------
// ray_square_closest_hit_core
// closest hit of one ray against a stream of squares
// ----------------------------------------------------------------------------
// Usage: write the ray (origin, direction, max distance) through the cfg
// port while the core is idle. Squares then arrive on the in channel
// (valid/ready); each is tested against the ray and the nearest hit kept.
// A square marked last produces one item on the out channel with the best
// hit (all zero fields when nothing was hit), and the core re-arms.
// Each square runs through both dot products on the shared multiplier and,
// unless rejected early, through the one-bit-per-cycle divider and the hit
// point test before the next square is accepted. The result item is
// registered once its last square reaches the final state and the output
// register is free. At most one square is in work.
// Reset clears the ray to origin zero, direction +z, max distance maximum.
// The result sits in an output register; if the receiver stalls, the next
// squares are still processed, and only a further last square waits until
// the held result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_square_closest_hit_core_macros.svh"
module ray_square_closest_hit_core import rsch_pkg::*; #(
  parameter int unsigned EPS_LSB    = 1,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire rsch_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rsch_out_t        out_data_o
);

  rsch_cmd_t  cmd;
  rsch_stat_t stat;

  // sequencer
  rsch_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // arithmetic and state
  rsch_dp #(.EPS_LSB(EPS_LSB), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_data_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // checks
  `RSCH_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `RSCH_ASSERT_IMP(a_load_needs_room, cmd.out_load, !out_valid_o || out_ready_i)
  `RSCH_ASSERT_IMP(a_div_not_idle, cmd.div_step || cmd.mul_en, !in_ready_o)

endmodule
`default_nettype wire
